@@ hdl/ale_pkg.sv @@
// ale_pkg: shared types and constants for the label encoder
// no dependencies; used by ale_ctrl, ale_dp and apn_label_encoder
package ale_pkg;

  // character codes
  localparam logic [7:0] DOT_CHAR = 8'h2E;
  localparam logic [7:0] NUL_CHAR = 8'h00;

  // most bytes a single request may produce
  localparam int MAX_RESULTS = 64;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEN,
    ST_DATA,
    ST_TRAIL
  } ale_state_t;

  // which byte the datapath loads into the output register
  typedef enum logic [1:0] {
    EM_NONE,
    EM_LEN,
    EM_DATA,
    EM_TRAIL
  } ale_emit_t;

  // controller to datapath
  typedef struct packed {
    logic      take;
    ale_emit_t emit;
  } ale_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic label_end;
    logic cnt_zero;
    logic trail;
    logic data_end;
    logic out_free;
  } ale_stat_t;

endpackage

@@ hdl/ale_if.sv @@
// ale_in_if / ale_out_if: valid-ready channels of the label encoder
// no dependencies
interface ale_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       name_last;

  modport source (output valid, output char_byte, output name_last, input ready);
  modport sink (input valid, input char_byte, input name_last, output ready);
endinterface

interface ale_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_length;
  logic       run_last;
  logic       name_done;
  logic       overflow;

  modport source (output valid, output out_byte, output is_length, output run_last,
                  output name_done, output overflow, input ready);
  modport sink (input valid, input out_byte, input is_length, input run_last,
                input name_done, input overflow, output ready);
endinterface

@@ hdl/ale_ram.sv @@
// ale_ram: generic single-write, single-read memory with registered read
// no dependencies
module ale_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/ale_ctrl.sv @@
// ale_ctrl: state machine that sequences accept, length, content and trailing bytes
// depends on ale_pkg
module ale_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ale_pkg::ale_stat_t stat,
  output ale_pkg::ale_cmd_t  cmd
);

  ale_pkg::ale_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ale_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd.take   = 1'b0;
    cmd.emit   = ale_pkg::EM_NONE;
    case (state)
      ale_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (stat.label_end) begin
            state_next = ale_pkg::ST_LEN;
          end
        end
      end
      ale_pkg::ST_LEN: begin
        if (stat.out_free) begin
          cmd.emit = ale_pkg::EM_LEN;
          if (!stat.cnt_zero) begin
            state_next = ale_pkg::ST_DATA;
          end else if (stat.trail) begin
            state_next = ale_pkg::ST_TRAIL;
          end else begin
            state_next = ale_pkg::ST_IDLE;
          end
        end
      end
      ale_pkg::ST_DATA: begin
        if (stat.out_free) begin
          cmd.emit = ale_pkg::EM_DATA;
          if (stat.data_end) begin
            state_next = stat.trail ? ale_pkg::ST_TRAIL : ale_pkg::ST_IDLE;
          end
        end
      end
      ale_pkg::ST_TRAIL: begin
        if (stat.out_free) begin
          cmd.emit   = ale_pkg::EM_TRAIL;
          state_next = ale_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ale_pkg::ST_IDLE;
      end
    endcase
  end

  // a label-ending request always starts a run with its length byte
  a_end_starts_run: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && stat.label_end) |=> (state == ale_pkg::ST_LEN))
    else $error("label end not followed by length state");

  // no byte is loaded over one the sink has not yet taken
  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit != ale_pkg::EM_NONE) |-> stat.out_free)
    else $error("output register overwritten");

  // after a run the block returns to taking characters
  a_trail_to_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit == ale_pkg::EM_TRAIL) |=> (state == ale_pkg::ST_IDLE))
    else $error("trailing byte not followed by idle");

endmodule

@@ hdl/ale_dp.sv @@
// ale_dp: label buffer, counters, run registers and output register
// depends on ale_pkg, ale_if (ale_out_if) and ale_ram
module ale_dp #(
  parameter int MAX_LABEL = 63
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         char_byte,
  input  logic               name_last,
  input  ale_pkg::ale_cmd_t  cmd,
  output ale_pkg::ale_stat_t stat,
  ale_out_if.source          dout
);

  localparam int CW = $clog2(MAX_LABEL + 1);
  localparam int AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;

  logic [CW-1:0] label_count;
  logic          label_ovf;
  logic [CW-1:0] run_cnt;
  logic          run_ovf;
  logic          run_done;
  logic          run_trail;
  logic [CW-1:0] rd_idx, rd_idx_next;
  logic          out_valid;
  logic [7:0]    out_byte;
  logic          out_is_len;
  logic          out_last;
  logic          out_done;
  logic          out_ovf;

  logic          is_dot, is_nul, is_content, room;
  logic [CW-1:0] cnt_after;
  logic          ovf_after;
  logic          trail_raw, over_budget, trail_ok;
  logic          wr_en;
  logic [7:0]    rdata;
  logic          data_end;

  // character classification and label bookkeeping
  always_comb begin
    is_dot      = (char_byte == ale_pkg::DOT_CHAR);
    is_nul      = (char_byte == ale_pkg::NUL_CHAR);
    is_content  = !is_dot && !is_nul;
    room        = (label_count < CW'(MAX_LABEL));
    cnt_after   = (is_content && room) ? label_count + CW'(1) : label_count;
    ovf_after   = label_ovf | (is_content & !room);
    trail_raw   = is_dot & name_last;
    over_budget = ((16'(cnt_after) + 16'd2) > 16'(ale_pkg::MAX_RESULTS));
    trail_ok    = trail_raw & !over_budget;
    wr_en       = cmd.take & is_content & room;
  end

  // label buffer
  ale_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LABEL)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (label_count[AW-1:0]),
    .wdata (char_byte),
    .raddr (rd_idx_next[AW-1:0]),
    .rdata (rdata)
  );

  // read pointer runs one address ahead so rdata matches rd_idx
  always_comb begin
    data_end    = (rd_idx == run_cnt - CW'(1));
    rd_idx_next = rd_idx;
    if (cmd.emit == ale_pkg::EM_DATA) begin
      rd_idx_next = data_end ? '0 : rd_idx + CW'(1);
    end else if (cmd.emit == ale_pkg::EM_LEN) begin
      rd_idx_next = '0;
    end
  end

  // status to the controller
  always_comb begin
    stat.label_end = is_dot | is_nul | name_last;
    stat.cnt_zero  = (run_cnt == '0);
    stat.trail     = run_trail;
    stat.data_end  = data_end;
    stat.out_free  = !out_valid | dout.ready;
  end

  // label counters and run registers
  always_ff @(posedge clk) begin
    if (rst) begin
      label_count <= '0;
      label_ovf   <= 1'b0;
      rd_idx      <= '0;
    end else begin
      rd_idx <= rd_idx_next;
      if (cmd.take) begin
        if (stat.label_end) begin
          label_count <= '0;
          label_ovf   <= 1'b0;
        end else begin
          label_count <= cnt_after;
          label_ovf   <= ovf_after;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && stat.label_end) begin
      run_cnt   <= cnt_after;
      run_ovf   <= ovf_after | (trail_raw & over_budget);
      run_done  <= (is_nul | name_last) & !trail_ok;
      run_trail <= trail_ok;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit != ale_pkg::EM_NONE) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    case (cmd.emit)
      ale_pkg::EM_LEN: begin
        out_byte   <= 8'(run_cnt);
        out_is_len <= 1'b1;
        out_last   <= (run_cnt == '0) & !run_trail;
        out_done   <= run_done;
        out_ovf    <= run_ovf;
      end
      ale_pkg::EM_DATA: begin
        out_byte   <= rdata;
        out_is_len <= 1'b0;
        out_last   <= data_end & !run_trail;
        out_done   <= run_done;
        out_ovf    <= run_ovf;
      end
      ale_pkg::EM_TRAIL: begin
        out_byte   <= 8'd0;
        out_is_len <= 1'b1;
        out_last   <= 1'b1;
        out_done   <= 1'b1;
        out_ovf    <= 1'b0;
      end
      default: begin
        out_byte   <= out_byte;
        out_is_len <= out_is_len;
        out_last   <= out_last;
        out_done   <= out_done;
        out_ovf    <= out_ovf;
      end
    endcase
  end

  assign dout.valid     = out_valid;
  assign dout.out_byte  = out_byte;
  assign dout.is_length = out_is_len;
  assign dout.run_last  = out_last;
  assign dout.name_done = out_done;
  assign dout.overflow  = out_ovf;

  // the buffer fill never passes its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    label_count <= CW'(MAX_LABEL))
    else $error("label count beyond buffer depth");

  // content reads stay inside the current label
  a_read_in_label: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit == ale_pkg::EM_DATA) |-> (rd_idx < run_cnt))
    else $error("content read past label end");

  // a trailing empty label only follows a run that asked for one
  a_trail_flag: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit == ale_pkg::EM_TRAIL) |-> run_trail)
    else $error("unexpected trailing label");

endmodule

@@ hdl/apn_label_encoder.sv @@
// apn_label_encoder: dotted name to length-prefixed label stream
// depends on ale_pkg, ale_if, ale_ram, ale_ctrl and ale_dp
//
//   channel  dir  payload                                           handshake
//   din      in   char_byte[7:0], name_last                         valid/ready
//   dout     out  out_byte[7:0], is_length, run_last, name_done,    valid/ready
//                 overflow
//
// a content character without name_last is taken while idle and gives no output
// a label-ending character is taken while idle, then its run goes out one byte a cycle
//   while the sink is ready: length byte, count content bytes, one more for a trailing dot
// the label buffer has one write and one registered read port, which sets the replay pace
// din.ready is low while a run is being sent; dout stalls hold the output register
// rst is synchronous; afterwards the buffer is empty and din.ready is high
module apn_label_encoder #(
  parameter int MAX_LABEL = 63
) (
  input  logic      clk,
  input  logic      rst,
  ale_in_if.sink    din,
  ale_out_if.source dout
);

  ale_pkg::ale_cmd_t  cmd;
  ale_pkg::ale_stat_t stat;
  logic               in_ready;

  assign din.ready = in_ready;

  ale_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ale_dp #(
    .MAX_LABEL (MAX_LABEL)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .char_byte (din.char_byte),
    .name_last (din.name_last),
    .cmd       (cmd),
    .stat      (stat),
    .dout      (dout)
  );

endmodule
